[rtl/stok_pkg.sv]
// Package: scanner types, token codes, keyword match function.
package stok_pkg;

	localparam int unsigned MaxSource = 65536;
	localparam int unsigned PosW = $clog2(MaxSource) + 1;
	localparam int unsigned QDepth = 2;

	typedef enum logic [3:0] {
		M_IDLE, M_BANG, M_EQUAL, M_LESS, M_GREATER, M_SLASH, M_COMMENT,
		M_STRING, M_INT, M_DOT, M_FRAC, M_IDENT
	} mode_t;

	localparam logic [5:0] T_DOT = 6'd5;
	localparam logic [5:0] T_BANG = 6'd10;
	localparam logic [5:0] T_BANG_EQ = 6'd11;
	localparam logic [5:0] T_EQ = 6'd12;
	localparam logic [5:0] T_EQ_EQ = 6'd13;
	localparam logic [5:0] T_GT = 6'd14;
	localparam logic [5:0] T_GT_EQ = 6'd15;
	localparam logic [5:0] T_LT = 6'd16;
	localparam logic [5:0] T_LT_EQ = 6'd17;
	localparam logic [5:0] T_SLASH = 6'd18;
	localparam logic [5:0] T_IDENT = 6'd19;
	localparam logic [5:0] T_STRING = 6'd20;
	localparam logic [5:0] T_NUMBER = 6'd21;
	localparam logic [5:0] T_KW_FIRST = 6'd22;
	localparam logic [5:0] T_EOF = 6'd38;

	localparam logic [1:0] E_NONE = 2'd0;
	localparam logic [1:0] E_UNEXPECTED = 2'd1;
	localparam logic [1:0] E_UNTERM = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] byte_req;
	} in_req_t;

	typedef struct packed {
		logic [5:0]  tok_code;
		logic [1:0]  error_code;
		logic [15:0] start_offset;
		logic [15:0] lexeme_length;
		logic [15:0] line;
		logic        last;
	} out_req_t;

	// one pending result slot
	typedef struct packed {
		logic [5:0]  tok_code;
		logic [1:0]  error_code;
		logic [15:0] start;
		logic [16:0] stop;
	} tok_t;

	// classified work for the back part: up to three tokens per input
	typedef struct packed {
		logic [1:0]  count;
		tok_t [2:0]  toks;
		logic [15:0] line;
	} batch_t;

	function automatic logic [5:0] kw_lookup(input logic [47:0] s, input logic [2:0] n);
		logic [5:0] r;
		r = T_IDENT;
		unique case (n)
			3'd2: begin
				if (s[47:32] == "if") r = T_KW_FIRST + 6'd6;
				else if (s[47:32] == "or") r = T_KW_FIRST + 6'd8;
			end
			3'd3: begin
				if (s[47:24] == "and") r = T_KW_FIRST;
				else if (s[47:24] == "for") r = T_KW_FIRST + 6'd4;
				else if (s[47:24] == "fun") r = T_KW_FIRST + 6'd5;
				else if (s[47:24] == "nil") r = T_KW_FIRST + 6'd7;
				else if (s[47:24] == "var") r = T_KW_FIRST + 6'd14;
			end
			3'd4: begin
				if (s[47:16] == "else") r = T_KW_FIRST + 6'd2;
				else if (s[47:16] == "this") r = T_KW_FIRST + 6'd12;
				else if (s[47:16] == "true") r = T_KW_FIRST + 6'd13;
			end
			3'd5: begin
				if (s[47:8] == "class") r = T_KW_FIRST + 6'd1;
				else if (s[47:8] == "false") r = T_KW_FIRST + 6'd3;
				else if (s[47:8] == "print") r = T_KW_FIRST + 6'd9;
				else if (s[47:8] == "super") r = T_KW_FIRST + 6'd11;
				else if (s[47:8] == "while") r = T_KW_FIRST + 6'd15;
			end
			3'd6: begin
				if (s == "return") r = T_KW_FIRST + 6'd10;
			end
			default: r = T_IDENT;
		endcase
		return r;
	endfunction

endpackage

[rtl/stok_front.sv]
// Front part: scan state, one byte per cycle while b_ready is high, builds token batches.
module stok_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  stok_pkg::in_req_t in_data,
	output logic              b_valid,
	input  logic              b_ready,
	output stok_pkg::batch_t  b_data
);

	stok_pkg::mode_t mode_q, mode_d;
	logic [15:0] start_q, start_d;
	logic [stok_pkg::PosW-1:0] pos_q, pos_d;
	logic [15:0] line_q, line_d;
	logic [7:0]  word_q [6];
	logic [2:0]  wlen_q, wlen_d;
	logic        wr_en;
	logic [2:0]  wr_idx;
	stok_pkg::batch_t bt;
	logic [16:0] p17, p1, pd;
	logic [15:0] ps;
	logic        go, fl, dig, alp;
	logic [7:0]  c;
	logic [1:0]  n;

	assign in_ready = b_ready;
	assign go = in_valid && in_ready;
	assign b_valid = in_valid;
	assign b_data = bt;
	assign c = in_data.byte_req;
	assign dig = c >= "0" && c <= "9";
	assign alp = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	assign p17 = pos_q > 17'(stok_pkg::MaxSource) ? 17'h1ffff : 17'(pos_q);
	assign ps = p17 > 17'd65535 ? 16'hffff : p17[15:0];
	assign p1 = p17 + 17'd1;
	assign pd = p17 != 17'd0 ? p17 - 17'd1 : 17'd0;

	always_comb begin
		mode_d = mode_q;
		start_d = start_q;
		pos_d = pos_q;
		line_d = line_q;
		wlen_d = wlen_q;
		wr_en = 1'b0;
		wr_idx = wlen_q;
		bt = '0;
		n = 2'd0;
		fl = 1'b0;
		if (in_data.kind) begin
			fl = 1'b1;
		end else begin
			unique case (mode_q)
				stok_pkg::M_BANG, stok_pkg::M_EQUAL, stok_pkg::M_LESS,
				stok_pkg::M_GREATER: fl = c != "=";
				stok_pkg::M_SLASH: fl = c != "/";
				stok_pkg::M_COMMENT: fl = c == 8'h0a;
				stok_pkg::M_STRING: fl = 1'b0;
				stok_pkg::M_INT: fl = !dig && c != ".";
				stok_pkg::M_DOT, stok_pkg::M_FRAC: fl = !dig;
				stok_pkg::M_IDENT: fl = !(alp || dig);
				default: fl = 1'b1;
			endcase
		end
		if (fl) begin
			unique case (mode_q)
				stok_pkg::M_BANG: bt.toks[0] = '{stok_pkg::T_BANG, stok_pkg::E_NONE, start_q, p17};
				stok_pkg::M_EQUAL: bt.toks[0] = '{stok_pkg::T_EQ, stok_pkg::E_NONE, start_q, p17};
				stok_pkg::M_LESS: bt.toks[0] = '{stok_pkg::T_LT, stok_pkg::E_NONE, start_q, p17};
				stok_pkg::M_GREATER: bt.toks[0] = '{stok_pkg::T_GT, stok_pkg::E_NONE, start_q, p17};
				stok_pkg::M_SLASH: bt.toks[0] = '{stok_pkg::T_SLASH, stok_pkg::E_NONE, start_q, p17};
				stok_pkg::M_STRING: bt.toks[0] = '{6'd0, stok_pkg::E_UNTERM, start_q, p17};
				stok_pkg::M_INT, stok_pkg::M_FRAC:
					bt.toks[0] = '{stok_pkg::T_NUMBER, stok_pkg::E_NONE, start_q, p17};
				stok_pkg::M_DOT: begin
					bt.toks[0] = '{stok_pkg::T_NUMBER, stok_pkg::E_NONE, start_q, pd};
					bt.toks[1] = '{stok_pkg::T_DOT, stok_pkg::E_NONE,
						pd > 17'd65535 ? 16'hffff : pd[15:0], p17};
				end
				stok_pkg::M_IDENT: bt.toks[0] = '{wlen_q == 3'd7 ? stok_pkg::T_IDENT :
					stok_pkg::kw_lookup({word_q[0], word_q[1], word_q[2], word_q[3],
					word_q[4], word_q[5]}, wlen_q), stok_pkg::E_NONE, start_q, p17};
				default: ;
			endcase
			priority case (mode_q)
				stok_pkg::M_IDLE, stok_pkg::M_COMMENT: n = 2'd0;
				stok_pkg::M_DOT: n = 2'd2;
				default: n = 2'd1;
			endcase
			mode_d = stok_pkg::M_IDLE;
		end
		if (in_data.kind) begin
			bt.toks[n] = '{stok_pkg::T_EOF, stok_pkg::E_NONE, ps, p17};
			n = n + 2'd1;
			mode_d = stok_pkg::M_IDLE;
			start_d = '0;
			pos_d = '0;
			line_d = 16'd1;
			wlen_d = '0;
		end else begin
			if (fl) begin
				priority if (c == "(" || c == ")" || c == "{" || c == "}" || c == "," ||
					c == "." || c == "-" || c == "+" || c == ";" || c == "*") begin
					bt.toks[n].error_code = stok_pkg::E_NONE;
					bt.toks[n].start = ps;
					bt.toks[n].stop = p1;
					unique case (c)
						"(": bt.toks[n].tok_code = 6'd0;
						")": bt.toks[n].tok_code = 6'd1;
						"{": bt.toks[n].tok_code = 6'd2;
						"}": bt.toks[n].tok_code = 6'd3;
						",": bt.toks[n].tok_code = 6'd4;
						".": bt.toks[n].tok_code = 6'd5;
						"-": bt.toks[n].tok_code = 6'd6;
						"+": bt.toks[n].tok_code = 6'd7;
						";": bt.toks[n].tok_code = 6'd8;
						default: bt.toks[n].tok_code = 6'd9;
					endcase
					n = n + 2'd1;
				end else if (c == "!") begin
					mode_d = stok_pkg::M_BANG; start_d = ps;
				end else if (c == "=") begin
					mode_d = stok_pkg::M_EQUAL; start_d = ps;
				end else if (c == "<") begin
					mode_d = stok_pkg::M_LESS; start_d = ps;
				end else if (c == ">") begin
					mode_d = stok_pkg::M_GREATER; start_d = ps;
				end else if (c == "/") begin
					mode_d = stok_pkg::M_SLASH; start_d = ps;
				end else if (c == " " || c == 8'h0d || c == 8'h09) begin
				end else if (c == 8'h0a) begin
					if (line_q != 16'hffff) line_d = line_q + 16'd1;
				end else if (c == "\"") begin
					mode_d = stok_pkg::M_STRING; start_d = ps;
				end else if (dig) begin
					mode_d = stok_pkg::M_INT; start_d = ps;
				end else if (alp) begin
					mode_d = stok_pkg::M_IDENT; start_d = ps;
					wr_en = 1'b1; wr_idx = 3'd0; wlen_d = 3'd1;
				end else begin
					bt.toks[n] = '{6'd0, stok_pkg::E_UNEXPECTED, ps, p1};
					n = n + 2'd1;
				end
			end else begin
				unique case (mode_q)
					stok_pkg::M_BANG: begin
						bt.toks[0] = '{stok_pkg::T_BANG_EQ, stok_pkg::E_NONE, start_q, p1};
						n = 2'd1; mode_d = stok_pkg::M_IDLE;
					end
					stok_pkg::M_EQUAL: begin
						bt.toks[0] = '{stok_pkg::T_EQ_EQ, stok_pkg::E_NONE, start_q, p1};
						n = 2'd1; mode_d = stok_pkg::M_IDLE;
					end
					stok_pkg::M_LESS: begin
						bt.toks[0] = '{stok_pkg::T_LT_EQ, stok_pkg::E_NONE, start_q, p1};
						n = 2'd1; mode_d = stok_pkg::M_IDLE;
					end
					stok_pkg::M_GREATER: begin
						bt.toks[0] = '{stok_pkg::T_GT_EQ, stok_pkg::E_NONE, start_q, p1};
						n = 2'd1; mode_d = stok_pkg::M_IDLE;
					end
					stok_pkg::M_SLASH: mode_d = stok_pkg::M_COMMENT;
					stok_pkg::M_STRING: begin
						if (c == 8'h0a && line_q != 16'hffff) line_d = line_q + 16'd1;
						if (c == "\"") begin
							bt.toks[0] = '{stok_pkg::T_STRING, stok_pkg::E_NONE, start_q, p1};
							n = 2'd1; mode_d = stok_pkg::M_IDLE;
						end
					end
					stok_pkg::M_INT: if (c == ".") mode_d = stok_pkg::M_DOT;
					stok_pkg::M_DOT: mode_d = stok_pkg::M_FRAC;
					stok_pkg::M_IDENT: begin
						wr_en = wlen_q < 3'd6;
						if (wlen_q != 3'd7) wlen_d = wlen_q + 3'd1;
					end
					default: ;
				endcase
			end
			if (pos_q < (stok_pkg::PosW)'(stok_pkg::MaxSource)) pos_d = pos_q + 1'b1;
		end
		bt.count = n;
		// tokens carry the line as it stood before this byte
		bt.line = line_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stok_pkg::M_IDLE;
			start_q <= '0;
			pos_q <= '0;
			line_q <= 16'd1;
			wlen_q <= '0;
		end else if (go) begin
			mode_q <= mode_d;
			start_q <= start_d;
			pos_q <= pos_d;
			line_q <= line_d;
			wlen_q <= wlen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go && wr_en) word_q[wr_idx] <= c;
	end

endmodule

[rtl/stok_queue.sv]
// Batch queue between front and back parts.
module stok_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             w_valid,
	output logic             w_ready,
	input  stok_pkg::batch_t w_data,
	output logic             r_valid,
	input  logic             r_ready,
	output stok_pkg::batch_t r_data
);

	localparam int unsigned AW = $clog2(stok_pkg::QDepth);
	stok_pkg::batch_t mem_q [stok_pkg::QDepth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          wr, rd;

	assign w_ready = cnt_q != (AW+1)'(stok_pkg::QDepth);
	assign r_valid = cnt_q != '0;
	assign r_data = mem_q[rp_q];
	assign wr = w_valid && w_ready && w_data.count != 2'd0;
	assign rd = r_valid && r_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= w_data;
	end

endmodule

[rtl/stok_back.sv]
// Back part: serializes token batches into results with lengths.
module stok_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               b_valid,
	output logic               b_ready,
	input  stok_pkg::batch_t   b_data,
	output logic               out_valid,
	input  logic               out_ready,
	output stok_pkg::out_req_t out_data
);

	logic [1:0]       idx_q;
	stok_pkg::tok_t   t;
	stok_pkg::out_req_t o;
	logic [16:0]      ln;
	logic             lst, take;

	assign t = b_data.toks[idx_q];
	assign lst = idx_q + 2'd1 == b_data.count;
	assign ln = t.stop > {1'b0, t.start} ? t.stop - {1'b0, t.start} : 17'd0;
	assign take = b_valid && (!out_valid || out_ready);
	assign b_ready = take && lst;

	always_comb begin
		o.tok_code = t.tok_code;
		o.error_code = t.error_code;
		o.start_offset = t.start;
		o.lexeme_length = ln[16] ? 16'hffff : ln[15:0];
		o.line = b_data.line;
		o.last = lst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				out_valid <= 1'b1;
				idx_q <= lst ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_data <= o;
	end

endmodule

[rtl/source_tokenizer.sv]
// Top level: streaming Lox scanner, front/queue/back.
// Usage:
//   in channel (in_valid/in_ready/in_data): one request per source byte,
//   kind=1 marks end of source. out channel (out_valid/out_ready/out_data):
//   zero to three token results per request, last set on the final one.
// Throughput: one request per cycle while each yields at most one result and
//   out_ready stays high; a request that yields several results occupies the back end until all are taken.
// A token's result is written to the queue at the edge that accepts the byte
//   that closes it, and from there is registered into the output register.
// A two-entry queue decouples the scanner from the result serializer, so
//   input keeps flowing while a result waits on out_ready.
// Stall: when out_ready is low the output holds; once the queue fills,
//   in_ready drops until the back end drains.
// Reset: scanner goes idle, line 1, offset 0; queue and output empty.
//   End of source restores the same scanner state for the next source.
module source_tokenizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  stok_pkg::in_req_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output stok_pkg::out_req_t out_data
);

	logic             f_valid, f_ready, q_valid, q_ready;
	stok_pkg::batch_t f_data, q_data;

	stok_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .b_valid(f_valid), .b_ready(f_ready), .b_data(f_data)
	);

	stok_queue u_queue (
		.clk(clk), .arst_n(arst_n), .w_valid(f_valid), .w_ready(f_ready),
		.w_data(f_data), .r_valid(q_valid), .r_ready(q_ready), .r_data(q_data)
	);

	stok_back u_back (
		.clk(clk), .arst_n(arst_n), .b_valid(q_valid), .b_ready(q_ready),
		.b_data(q_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

`ifndef SYNTHESIS
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tok_code == stok_pkg::T_EOF &&
		out_data.error_code == stok_pkg::E_NONE
		|-> out_data.last) else $error("eof not last");
	a_err_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code != stok_pkg::E_NONE |-> out_data.tok_code == 6'd0)
		else $error("error result with type");
	a_line_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.line != 16'd0) else $error("line zero");
	a_q_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> q_data.count != 2'd0) else $error("empty batch queued");
`endif

endmodule
